### rtl/qoi_pkg.sv
// ----------------------------------------------------------------------------
// QOI encoder package
// Shared types, chunk opcodes and the colour index hash.
// ----------------------------------------------------------------------------
package qoi_pkg;

	localparam int INDEX_SLOTS = 64;
	localparam int IDX_W       = $clog2(INDEX_SLOTS);
	localparam int RUN_W       = 6;
	localparam int MAX_RUN_DEF = 62;
	localparam int MAX_BYTES   = 6;
	localparam int CNT_W       = $clog2(MAX_BYTES + 1);

	localparam logic [7:0] OP_INDEX = 8'h00;
	localparam logic [7:0] OP_DIFF  = 8'h40;
	localparam logic [7:0] OP_LUMA  = 8'h80;
	localparam logic [7:0] OP_RUN   = 8'hC0;
	localparam logic [7:0] OP_RGB   = 8'hFE;
	localparam logic [7:0] OP_RGBA  = 8'hFF;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	localparam pixel_t OPAQUE_BLACK = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

	// Coder result: bytes in emission order, element 0 first.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] data;
		logic [CNT_W-1:0]          cnt;
		logic                      idx_we;
		logic [RUN_W-1:0]          run_nxt;
	} chunk_t;

	function automatic logic [IDX_W-1:0] colour_slot(input pixel_t p);
		logic [IDX_W-1:0] s;
		s = IDX_W'(p.r) * IDX_W'(3) + IDX_W'(p.g) * IDX_W'(5)
		  + IDX_W'(p.b) * IDX_W'(7) + IDX_W'(p.a) * IDX_W'(11);
		return s;
	endfunction

endpackage

### rtl/qoi_if.sv
// ----------------------------------------------------------------------------
// QOI encoder channels
// Pixel input channel and chunk byte output channel, valid/ready.
// ----------------------------------------------------------------------------
interface qoi_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       block_end;

	modport source (output valid, red, green, blue, alpha, block_end, input ready);
	modport sink   (input valid, red, green, blue, alpha, block_end, output ready);
endinterface

interface qoi_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       item_last;
	logic       block_last;

	modport source (output valid, out_byte, item_last, block_last, input ready);
	modport sink   (input valid, out_byte, item_last, block_last, output ready);
endinterface

### rtl/qoi_idx_ram.sv
// ----------------------------------------------------------------------------
// QOI colour index
// 64-entry index memory with registered read, valid bits and write bypass.
// ----------------------------------------------------------------------------
module qoi_idx_ram (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [qoi_pkg::IDX_W-1:0] rd_addr,
	input  logic                  wr_en,
	input  logic [qoi_pkg::IDX_W-1:0] wr_addr,
	input  qoi_pkg::pixel_t       wr_data,
	output qoi_pkg::pixel_t       rd_data
);
	import qoi_pkg::*;

	pixel_t                 mem [INDEX_SLOTS];
	logic [INDEX_SLOTS-1:0] vld_q;
	pixel_t                 rd_q;
	logic                   rd_vld_q;
	logic                   fwd_q;
	pixel_t                 fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
				fwd_q    <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

### rtl/qoi_chunk.sv
// ----------------------------------------------------------------------------
// QOI chunk coder
// Picks RUN / INDEX / DIFF / LUMA / RGB / RGBA bytes for one pixel.
// ----------------------------------------------------------------------------
module qoi_chunk #(
	parameter int MAX_RUN = qoi_pkg::MAX_RUN_DEF
) (
	input  qoi_pkg::pixel_t            px,
	input  logic                       last,
	input  logic [qoi_pkg::IDX_W-1:0]  slot,
	input  qoi_pkg::pixel_t            entry,
	input  qoi_pkg::pixel_t            prev,
	input  logic [qoi_pkg::RUN_W-1:0]  run,
	output qoi_pkg::chunk_t            res
);
	import qoi_pkg::*;

	always_comb begin
		logic              eq;
		logic [RUN_W-1:0]  run_inc;
		logic              flush;
		logic [7:0]        run_byte;
		logic signed [8:0] dr, dg, db, da;
		logic signed [9:0] drg, dbg;
		logic signed [8:0] tr, tg, tb;
		logic signed [9:0] tl0, tl1;
		logic signed [8:0] tlg;
		logic [4:0][7:0]   c;
		logic [2:0]        clen;

		eq      = (px == prev);
		run_inc = run + RUN_W'(1);
		dr  = $signed({1'b0, px.r}) - $signed({1'b0, prev.r});
		dg  = $signed({1'b0, px.g}) - $signed({1'b0, prev.g});
		db  = $signed({1'b0, px.b}) - $signed({1'b0, prev.b});
		da  = $signed({1'b0, px.a}) - $signed({1'b0, prev.a});
		drg = 10'(dr) - 10'(dg);
		dbg = 10'(db) - 10'(dg);
		tr  = dr + 9'sd2;
		tg  = dg + 9'sd2;
		tb  = db + 9'sd2;
		tlg = dg + 9'sd32;
		tl0 = drg + 10'sd8;
		tl1 = dbg + 10'sd8;

		c    = '0;
		clen = 3'd0;
		res  = '0;

		if (eq) begin
			flush       = (run_inc >= RUN_W'(MAX_RUN)) || last;
			run_byte    = OP_RUN | {2'b00, run_inc - RUN_W'(1)};
			res.idx_we  = 1'b1;
			res.run_nxt = flush ? '0 : run_inc;
		end else begin
			flush       = (run != '0);
			run_byte    = OP_RUN | {2'b00, run - RUN_W'(1)};
			res.run_nxt = '0;
			if (entry == px) begin
				c[0] = OP_INDEX | {2'b00, slot};
				clen = 3'd1;
			end else begin
				res.idx_we = 1'b1;
				if (da == 9'sd0 && dr >= -9'sd2 && dr <= 9'sd1 && dg >= -9'sd2
						&& dg <= 9'sd1 && db >= -9'sd2 && db <= 9'sd1) begin
					c[0] = OP_DIFF | {2'b00, tr[1:0], tg[1:0], tb[1:0]};
					clen = 3'd1;
				end else if (da == 9'sd0 && dg >= -9'sd32 && dg <= 9'sd31
						&& drg >= -10'sd8 && drg <= 10'sd7
						&& dbg >= -10'sd8 && dbg <= 10'sd7) begin
					c[0] = OP_LUMA | {2'b00, tlg[5:0]};
					c[1] = {tl0[3:0], tl1[3:0]};
					clen = 3'd2;
				end else if (da == 9'sd0) begin
					c[0] = OP_RGB;
					c[1] = px.r;
					c[2] = px.g;
					c[3] = px.b;
					clen = 3'd4;
				end else begin
					c[0] = OP_RGBA;
					c[1] = px.r;
					c[2] = px.g;
					c[3] = px.b;
					c[4] = px.a;
					clen = 3'd5;
				end
			end
		end

		if (flush) begin
			res.data = {c, run_byte};
			res.cnt  = CNT_W'(clen) + CNT_W'(1);
		end else begin
			res.data = {8'h00, c};
			res.cnt  = CNT_W'(clen);
		end
	end

endmodule

### rtl/qoi_ser.sv
// ----------------------------------------------------------------------------
// QOI byte serialiser
// Holds one pixel's chunk bytes and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module qoi_ser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  qoi_pkg::chunk_t   res,
	input  logic              blk_end,
	output logic              load_ok,
	qoi_byte_if.source        chunk
);
	import qoi_pkg::*;

	logic [MAX_BYTES-1:0][7:0] buf_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      blk_q;
	logic                      take;

	assign take    = chunk.valid && chunk.ready;
	// free once the final byte of the current chunk leaves
	assign load_ok = (cnt_q == '0) || (cnt_q == CNT_W'(1) && chunk.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.data;
			blk_q <= blk_end;
		end else if (take) begin
			buf_q <= buf_q >> 8;
		end
	end

	assign chunk.valid      = (cnt_q != '0);
	assign chunk.out_byte   = buf_q[0];
	assign chunk.item_last  = (cnt_q == CNT_W'(1));
	assign chunk.block_last = (cnt_q == CNT_W'(1)) && blk_q;

endmodule

### rtl/qoi_pixel_encoder.sv
// ----------------------------------------------------------------------------
// QOI pixel encoder
// Streaming QOI chunk encoder: one RGBA pixel in, its chunk bytes out.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat                                   | ends
//  --------+-----+----------------------------------------+---------------------
//  pix     | in  | red, green, blue, alpha, block_end     | block_end = 1
//  chunk   | out | out_byte, item_last, block_last        | block_last = 1
//
//  - Pixel register (s1) then chunk coder then byte serialiser. First byte of
//    a pixel shows on chunk after s1 and the serialiser register; s1 can stall.
//  - A pixel giving no bytes leaves s1 without the serialiser; a pixel giving
//    bytes (up to six: run flush plus RGBA) holds the coder until the
//    serialiser is free, which sends one byte per cycle while chunk is ready.
//  - The index memory is read at pix acceptance, registered; a write to the
//    same slot in that cycle is bypassed.
//  - Reset: previous pixel opaque black, run empty, index valid bits cleared
//    at once, so no clearing pass is needed.
//  - chunk stalls back up through the coder into pix.ready.
//
module qoi_pixel_encoder #(
	parameter int MAX_RUN = qoi_pkg::MAX_RUN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qoi_pix_if.sink    pix,
	qoi_byte_if.source chunk
);
	import qoi_pkg::*;

	// input stage
	logic             valid_s1;
	pixel_t           px_s1;
	logic             last_s1;
	logic [IDX_W-1:0] slot_s1;

	// encoder state
	pixel_t           prev_q;
	logic [RUN_W-1:0] run_q;

	pixel_t           px_in;
	pixel_t           entry;
	chunk_t           res;
	logic             load_ok;
	logic             adv;
	logic             acc;

	assign px_in = '{r: pix.red, g: pix.green, b: pix.blue, a: pix.alpha};

	// s1 moves on when it has no bytes or the serialiser can take them
	assign adv       = valid_s1 && ((res.cnt == '0) || load_ok);
	assign pix.ready = !valid_s1 || adv;
	assign acc       = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prev_q   <= OPAQUE_BLACK;
			run_q    <= '0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				prev_q <= px_s1;
				run_q  <= res.run_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1   <= px_in;
			last_s1 <= pix.block_end;
			slot_s1 <= colour_slot(px_in);
		end
	end

	qoi_idx_ram u_idx (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (colour_slot(px_in)),
		.wr_en   (adv && res.idx_we),
		.wr_addr (slot_s1),
		.wr_data (px_s1),
		.rd_data (entry)
	);

	qoi_chunk #(
		.MAX_RUN (MAX_RUN)
	) u_chunk (
		.px    (px_s1),
		.last  (last_s1),
		.slot  (slot_s1),
		.entry (entry),
		.prev  (prev_q),
		.run   (run_q),
		.res   (res)
	);

	qoi_ser u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv && (res.cnt != '0)),
		.res     (res),
		.blk_end (last_s1),
		.load_ok (load_ok),
		.chunk   (chunk)
	);

	// pending run never reaches the flush limit between pixels
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q < RUN_W'(MAX_RUN))
		else $error("run counter reached flush limit");

	// a silent pixel is always a run pixel
	a_silent_run: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (res.cnt == '0) |-> (px_s1 == prev_q) && !last_s1)
		else $error("pixel dropped without bytes");

	// loaded bytes show on chunk the next cycle
	a_bytes_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (res.cnt != '0) |=> chunk.valid)
		else $error("chunk bytes lost");

endmodule
